### design/polyline_stream_decoder_core_defines.svh
// Assertion macros shared by the decoder modules.
// PSD_ASSERT checks a property on every rising clock edge outside reset.
// PSD_ASSERT_ALWAYS checks a property on every rising clock edge, reset included.
`ifndef POLYLINE_STREAM_DECODER_CORE_DEFINES_SVH
`define POLYLINE_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH
`define PSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PSD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSD_ASSERT(label, clk, rst, prop, msg)
`define PSD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### design/psd_pkg.sv
package psd_pkg;

   // Field widths fixed by the interface.
   localparam int CHAR_WIDTH   = 7;
   localparam int FIELD_WIDTH  = 32;
   localparam int CHUNK_BITS   = 5;
   localparam int OFFSET_WIDTH = 6;

   // Default configuration of the core.
   localparam int COORD_WIDTH_DEFAULT  = 32;
   localparam int ITEM_DEPTH_DEFAULT   = 2;
   localparam int RESULT_DEPTH_DEFAULT = 2;

   // Character decoding constants.
   localparam logic [CHAR_WIDTH-1:0]   CHAR_BIAS     = 7'd63;
   localparam logic [CHAR_WIDTH-1:0]   CHUNK_CONT    = 7'h20;
   localparam logic [OFFSET_WIDTH-1:0] OFFSET_BEYOND = 6'd63;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_POINT = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // One classified character, as handed from the front to the decoder.
   typedef struct packed {
      logic [CHUNK_BITS-1:0] chunk;
      logic                  more;
      logic                  last;
      logic                  is_sep;
   } item_type;

   // One result word.
   typedef struct packed {
      kind_type                 kind;
      logic signed [FIELD_WIDTH-1:0] lat;
      logic signed [FIELD_WIDTH-1:0] lon;
      logic                     fin;
   } result_type;

endpackage

### design/psd_fifo.sv
`include "polyline_stream_decoder_core_defines.svh"

module psd_fifo #(
   parameter int  DEPTH = 2,
   parameter type entry_type = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // Handshake qualification.
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage carries payload only, so it has no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PSD_ASSERT(a_count_in_range, clock, reset, (count_ff <= CNT_W'(DEPTH)), "fifo overfilled")
   `PSD_ASSERT(a_ptr_gap, clock, reset, (empty |-> (wr_ptr_ff == rd_ptr_ff)), "fifo pointers disagree")

endmodule

### design/psd_front.sv
module psd_front import psd_pkg::*; #(
   parameter int DEPTH = ITEM_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [CHAR_WIDTH-1:0] char_code,
   input  logic                  stream_end,
   input  logic                  csr_write_en,
   input  logic [CHAR_WIDTH-1:0] csr_write_data,
   output logic                  item_valid,
   output item_type              item,
   input  logic                  item_take
);

   logic [CHAR_WIDTH-1:0] separator_ff;
   logic [CHAR_WIDTH-1:0] biased;
   item_type              class_item;
   logic                  item_empty;

   // Separator register: the user must write it only while the block is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= '0;
      end else if (csr_write_en) begin
         separator_ff <= csr_write_data;
      end
   end

   // Classify the character: the chunk is the low bits of code minus the bias, and the
   // value continues when the code reaches the bias plus the continuation flag.
   assign biased            = char_code - CHAR_BIAS;
   assign class_item.chunk  = biased[CHUNK_BITS-1:0];
   assign class_item.more   = (char_code >= (CHAR_BIAS + CHUNK_CONT));
   assign class_item.last   = stream_end;
   assign class_item.is_sep = (char_code == separator_ff);

   // Short queue that lets the front keep accepting while the decoder stalls.
   psd_fifo #(
      .DEPTH      (DEPTH),
      .entry_type (item_type)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (class_item),
      .full      (full),
      .pop       (item_take),
      .pop_data  (item),
      .empty     (item_empty)
   );

   assign item_valid = !item_empty;

endmodule

### design/psd_exec.sv
`include "polyline_stream_decoder_core_defines.svh"

module psd_exec import psd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_take,
   input  logic       result_full,
   output logic       result_push,
   output result_type result
);

   localparam int SUM_W = OFFSET_WIDTH + 1;

   logic signed [COORD_WIDTH-1:0] lat_total_ff, lat_total_in;
   logic signed [COORD_WIDTH-1:0] lon_total_ff, lon_total_in;
   logic        [COORD_WIDTH-1:0] gather_ff, gather_in;
   logic     [OFFSET_WIDTH-1:0]   offset_ff, offset_in;
   logic                          second_ff, second_in;
   logic                          after_point_ff, after_point_in;

   logic                          step;
   logic                          in_range;
   logic        [COORD_WIDTH-1:0] gather_new;
   logic            [SUM_W-1:0]   offset_sum;
   logic     [OFFSET_WIDTH-1:0]   offset_new;
   logic signed [COORD_WIDTH-1:0] half;
   logic signed [COORD_WIDTH-1:0] diff;

   // A word is taken whenever one waits and the result queue has room.
   assign step      = item_valid && !result_full;
   assign item_take = step;

   // Chunk gathering: bits that land beyond the coordinate width are dropped.
   assign in_range   = (offset_ff != OFFSET_BEYOND) &&
                       ({1'b0, offset_ff} < SUM_W'(COORD_WIDTH));
   assign gather_new = in_range ?
                       (gather_ff | (COORD_WIDTH'(item.chunk) << offset_ff)) : gather_ff;
   assign offset_sum = {1'b0, offset_ff} + SUM_W'(CHUNK_BITS);
   assign offset_new = ((offset_ff == OFFSET_BEYOND) || (offset_sum >= SUM_W'(COORD_WIDTH))) ?
                       OFFSET_BEYOND : offset_sum[OFFSET_WIDTH-1:0];

   // Zigzag decode of the completed value.
   assign half = $signed(gather_new) >>> 1;
   assign diff = gather_new[0] ? ~half : half;

   // Decoder step for one character.
   always_comb begin
      lat_total_in   = lat_total_ff;
      lon_total_in   = lon_total_ff;
      gather_in      = gather_ff;
      offset_in      = offset_ff;
      second_in      = second_ff;
      after_point_in = after_point_ff;
      result_push    = 1'b0;
      result.kind    = KIND_POINT;
      result.lat     = '0;
      result.lon     = '0;
      result.fin     = 1'b0;
      if (step) begin
         if (after_point_ff && item.is_sep) begin
            // Separator right after a point closes the polyline.
            lat_total_in   = '0;
            lon_total_in   = '0;
            gather_in      = '0;
            offset_in      = '0;
            second_in      = 1'b0;
            after_point_in = 1'b0;
            result_push    = 1'b1;
            result.kind    = KIND_END;
            result.fin     = item.last;
         end else begin
            after_point_in = 1'b0;
            gather_in      = gather_new;
            offset_in      = offset_new;
            if (!item.more) begin
               gather_in = '0;
               offset_in = '0;
               if (!second_ff) begin
                  lat_total_in = lat_total_ff + diff;
                  second_in    = 1'b1;
               end else begin
                  lon_total_in = lon_total_ff + diff;
                  second_in    = 1'b0;
                  if (!item.last) begin
                     after_point_in = 1'b1;
                     result_push    = 1'b1;
                     result.kind    = KIND_POINT;
                     result.lat     = FIELD_WIDTH'(lat_total_ff);
                     result.lon     = FIELD_WIDTH'(lon_total_in);
                  end
               end
            end
            if (item.last) begin
               // The stream stopped without a closing separator.
               lat_total_in   = '0;
               lon_total_in   = '0;
               gather_in      = '0;
               offset_in      = '0;
               second_in      = 1'b0;
               after_point_in = 1'b0;
               result_push    = 1'b1;
               result.kind    = KIND_ERROR;
               result.fin     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_total_ff   <= '0;
         lon_total_ff   <= '0;
         gather_ff      <= '0;
         offset_ff      <= '0;
         second_ff      <= 1'b0;
         after_point_ff <= 1'b0;
      end else begin
         lat_total_ff   <= lat_total_in;
         lon_total_ff   <= lon_total_in;
         gather_ff      <= gather_in;
         offset_ff      <= offset_in;
         second_ff      <= second_in;
         after_point_ff <= after_point_in;
      end
   end

   `PSD_ASSERT(a_point_pairs, clock, reset, (after_point_ff |-> !second_ff), "point left a half pair")
   `PSD_ASSERT(a_close_clears, clock, reset, ((result_push && (result.kind != KIND_POINT)) |=> ((lat_total_ff == '0) && (lon_total_ff == '0) && (offset_ff == '0))), "sums not cleared after close")

endmodule

### design/polyline_stream_decoder_core.sv
// Decoder for a stream of encoded-polyline characters. One character is accepted per
// cycle on the push/full side while full is low; at most one result word per character
// comes out on the empty/pop side: a decoded point, the end of a polyline, or an error
// when the stream stops mid-value or without a closing separator. A front stage
// classifies each character into a short queue; the decoder takes one character per
// cycle while the result queue has room, its step a shift-or of a chunk, zigzag decode
// and one coordinate add. A character is registered in the item queue and its result
// in the result queue; a full result queue holds the decoder back until words are
// popped. The separator register may be written only while the block is idle.
module polyline_stream_decoder_core import psd_pkg::*; #(
   parameter int COORD_WIDTH  = COORD_WIDTH_DEFAULT,
   parameter int ITEM_DEPTH   = ITEM_DEPTH_DEFAULT,
   parameter int RESULT_DEPTH = RESULT_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [CHAR_WIDTH-1:0]         req_char_code,
   input  logic                          req_stream_end,
   output logic                          empty,
   input  logic                          pop,
   output logic [1:0]                    rsp_kind,
   output logic signed [FIELD_WIDTH-1:0] rsp_latitude_sum,
   output logic signed [FIELD_WIDTH-1:0] rsp_longitude_sum,
   output logic                          rsp_final_result,
   input  logic                          csr_write_en,
   input  logic [CHAR_WIDTH-1:0]         csr_write_data
);

   logic       item_valid;
   item_type   item;
   logic       item_take;
   logic       result_full;
   logic       result_push;
   result_type result;
   result_type rsp_word;

   // Front: accept and classify characters.
   psd_front #(
      .DEPTH (ITEM_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .char_code      (req_char_code),
      .stream_end     (req_stream_end),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .item_valid     (item_valid),
      .item           (item),
      .item_take      (item_take)
   );

   // Back: running decode state.
   psd_exec #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_exec (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .item_take   (item_take),
      .result_full (result_full),
      .result_push (result_push),
      .result      (result)
   );

   // Result queue towards the consumer.
   psd_fifo #(
      .DEPTH      (RESULT_DEPTH),
      .entry_type (result_type)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .full      (result_full),
      .pop       (pop),
      .pop_data  (rsp_word),
      .empty     (empty)
   );

   assign rsp_kind          = rsp_word.kind;
   assign rsp_latitude_sum  = rsp_word.lat;
   assign rsp_longitude_sum = rsp_word.lon;
   assign rsp_final_result  = rsp_word.fin;

endmodule

### bench/polyline_stream_decoder_core_tb.sv
module polyline_stream_decoder_core_tb;
   import psd_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MAX_PRINTED    = 40;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          push = 1'b0;
   logic                          full;
   logic [CHAR_WIDTH-1:0]         req_char_code = '0;
   logic                          req_stream_end = 1'b0;
   logic                          empty;
   logic                          pop = 1'b0;
   logic [1:0]                    rsp_kind;
   logic signed [FIELD_WIDTH-1:0] rsp_latitude_sum;
   logic signed [FIELD_WIDTH-1:0] rsp_longitude_sum;
   logic                          rsp_final_result;
   logic                          csr_write_en = 1'b0;
   logic [CHAR_WIDTH-1:0]         csr_write_data = '0;

   // Own copy of the decoder state and the separator register.
   logic [FIELD_WIDTH-1:0]  lat_acc;
   logic [FIELD_WIDTH-1:0]  lon_acc;
   logic [FIELD_WIDTH-1:0]  gather_bits;
   logic [OFFSET_WIDTH-1:0] gather_pos;
   logic                    on_longitude;
   logic                    point_done;
   logic [CHAR_WIDTH-1:0]   separator_reg = '0;

   // Words still to come from the block, oldest first.
   result_type awaited_words[$];

   // Characters of one encoded coordinate difference.
   logic [CHAR_WIDTH-1:0] char_buf[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int chars_sent         = 0;
   int mismatch_count     = 0;
   int quiet_cycles       = 0;

   polyline_stream_decoder_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_char_code     (req_char_code),
      .req_stream_end    (req_stream_end),
      .empty             (empty),
      .pop               (pop),
      .rsp_kind          (rsp_kind),
      .rsp_latitude_sum  (rsp_latitude_sum),
      .rsp_longitude_sum (rsp_longitude_sum),
      .rsp_final_result  (rsp_final_result),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Returns every state entry of the decoder to its reset value.
   function automatic void clear_decoder();
      lat_acc      = '0;
      lon_acc      = '0;
      gather_bits  = '0;
      gather_pos   = '0;
      on_longitude = 1'b0;
      point_done   = 1'b0;
   endfunction

   // Decodes one accepted character and queues the word it causes, if any.
   task automatic decode_char(input logic [CHAR_WIDTH-1:0] ch, input logic last);
      result_type             word;
      logic [7:0]             diff8;
      logic [FIELD_WIDTH-1:0] gathered;
      logic [FIELD_WIDTH-1:0] half;
      logic [FIELD_WIDTH-1:0] delta;
      int                     next_pos;
      word.kind = KIND_POINT;
      word.lat  = '0;
      word.lon  = '0;
      word.fin  = last;
      // A separator straight after a point closes the polyline.
      if (point_done && ch == separator_reg) begin
         clear_decoder();
         word.kind = KIND_END;
         awaited_words.push_back(word);
         return;
      end
      point_done = 1'b0;
      // Gather the chunk; bits beyond the coordinate width are dropped.
      diff8 = {1'b0, ch} - {1'b0, CHAR_BIAS};
      if (gather_pos != OFFSET_BEYOND && gather_pos < FIELD_WIDTH) begin
         gather_bits = gather_bits | (FIELD_WIDTH'(diff8[CHUNK_BITS-1:0]) << gather_pos);
      end
      next_pos = gather_pos + CHUNK_BITS;
      if (gather_pos == OFFSET_BEYOND || next_pos >= FIELD_WIDTH) begin
         next_pos = OFFSET_BEYOND;
      end
      gather_pos = next_pos[OFFSET_WIDTH-1:0];
      // A chunk below the continuation flag ends the value: undo the zigzag and add.
      if (ch < CHAR_BIAS + CHUNK_CONT) begin
         gathered    = gather_bits;
         half        = {gathered[FIELD_WIDTH-1], gathered[FIELD_WIDTH-1:1]};
         delta       = gathered[0] ? ~half : half;
         gather_bits = '0;
         gather_pos  = '0;
         if (!on_longitude) begin
            lat_acc      = lat_acc + delta;
            on_longitude = 1'b1;
         end else begin
            lon_acc      = lon_acc + delta;
            on_longitude = 1'b0;
            if (!last) begin
               point_done = 1'b1;
               word.lat   = lat_acc;
               word.lon   = lon_acc;
               awaited_words.push_back(word);
               return;
            end
         end
      end
      // The final character of a stream that is not properly closed is an error.
      if (last) begin
         clear_decoder();
         word.kind = KIND_ERROR;
         awaited_words.push_back(word);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTED) begin
         $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
      end
      mismatch_count++;
   endtask

   // Compares the word on the result ports with the oldest awaited one.
   task automatic check_word();
      result_type want;
      if (awaited_words.size() == 0) begin
         report_mismatch("word with none awaited", rsp_kind, '0);
         return;
      end
      want = awaited_words.pop_front();
      if (rsp_kind !== want.kind) report_mismatch("kind", rsp_kind, want.kind);
      if (rsp_latitude_sum !== want.lat) report_mismatch("latitude", rsp_latitude_sum, want.lat);
      if (rsp_longitude_sum !== want.lon) begin
         report_mismatch("longitude", rsp_longitude_sum, want.lon);
      end
      if (rsp_final_result !== want.fin) report_mismatch("final flag", rsp_final_result, want.fin);
   endtask

   // Receiver: takes each word on offer and stalls at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) check_word();
         pop <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", quiet_cycles);
         $display("polyline_stream_decoder_core_tb: FAIL");
         $finish;
      end
   end

   // Offers one character, idling at random first, and waits until it is taken.
   task automatic send_char(input logic [CHAR_WIDTH-1:0] ch, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push           <= 1'b1;
      req_char_code  <= ch;
      req_stream_end <= last;
      @(posedge clock);
      while (full) @(posedge clock);
      decode_char(ch, last);
      chars_sent++;
   endtask

   // Holds the sender back until every awaited word has arrived.
   task automatic wait_for_drain();
      push <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
   endtask

   task automatic set_separator(input logic [CHAR_WIDTH-1:0] sep);
      wait_for_drain();
      // Characters that cause no word may still be inside the block.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= sep;
      @(posedge clock);
      csr_write_en  <= 1'b0;
      separator_reg = sep;
   endtask

   // Zigzag-codes a difference into characters, low chunk first.
   function automatic void encode_delta(input logic [31:0] d);
      logic [31:0] z;
      z = d[31] ? ~(d << 1) : (d << 1);
      char_buf.delete();
      while (z >= 32'(CHUNK_CONT)) begin
         char_buf.push_back(CHAR_WIDTH'((z & 32'h1f) | 32'h20) + CHAR_BIAS);
         z = z >> CHUNK_BITS;
      end
      char_buf.push_back(CHAR_WIDTH'(z) + CHAR_BIAS);
   endfunction

   function automatic logic [31:0] rand_delta();
      case ($urandom_range(3))
         0: return $urandom_range(2000) - 1000;
         1: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
         2: return $urandom;
         default: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               default: return 32'h0;
            endcase
         end
      endcase
   endfunction

   task automatic send_delta(input logic [31:0] d, input logic last);
      logic [CHAR_WIDTH-1:0] chars[$];
      encode_delta(d);
      chars = char_buf;
      foreach (chars[i]) send_char(chars[i], last && (i == chars.size() - 1));
   endtask

   task automatic send_points(input int count);
      for (int i = 0; i < count; i++) begin
         send_delta(rand_delta(), 1'b0);
         send_delta(rand_delta(), 1'b0);
      end
   endtask

   // One random stream: mostly well-formed polylines, some noise and truncation.
   task automatic send_random_stream();
      logic [CHAR_WIDTH-1:0] chars[$];
      int                    shape;
      int                    count;
      int                    cut;
      logic                  close;
      shape = $urandom_range(9);
      if (shape == 0) begin
         count = $urandom_range(1, 12);
         close = 1'($urandom_range(1));
         for (int i = 0; i < count; i++) begin
            send_char(CHAR_WIDTH'($urandom_range(127)), close && (i == count - 1));
         end
      end else if (shape == 1) begin
         // Stream stopping somewhere inside a value.
         send_points($urandom_range(3));
         encode_delta(rand_delta());
         chars = char_buf;
         cut   = $urandom_range(1, chars.size());
         for (int i = 0; i < cut; i++) send_char(chars[i], i == cut - 1);
      end else if (shape == 2) begin
         // Stream ending on a complete point with no closing separator.
         send_points($urandom_range(2));
         send_delta(rand_delta(), 1'b0);
         send_delta(rand_delta(), 1'b1);
      end else begin
         // A stray separator that follows no point is plain data.
         if (shape == 3) send_char(separator_reg, 1'b0);
         count = $urandom_range(1, 3);
         for (int i = 0; i < count; i++) begin
            send_points($urandom_range(1, 4));
            send_char(separator_reg, i == count - 1);
         end
      end
   endtask

   task automatic run_random_streams(input int count);
      int target;
      target = chars_sent + count;
      while (chars_sent < target) send_random_stream();
   endtask

   // Hand-picked streams under the reset separator of 0.
   task automatic test_directed_cases();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      // Point at the origin, then the separator closes the polyline.
      send_char(7'd63, 1'b0);
      send_char(7'd63, 1'b0);
      send_char(7'd0, 1'b0);
      // Lowest character as data, then the highest character as a continuation.
      send_char(7'd0, 1'b0);
      send_char(7'd127, 1'b0);
      send_char(7'd63, 1'b0);
      // Overlong latitude: continuation chunks run past the coordinate width.
      repeat (8) send_char(7'd126, 1'b0);
      send_char(7'd94, 1'b0);
      send_char(7'd94, 1'b0);
      // Separator after a point on the final character.
      send_char(7'd0, 1'b1);
      // Final character in the middle of a value.
      send_char(7'd127, 1'b0);
      send_char(7'd127, 1'b1);
      // Final character completing a point with no separator.
      send_char(7'd63, 1'b0);
      send_char(7'd63, 1'b1);
      // Final character as the first of a stream.
      send_char(7'd63, 1'b1);
      // Separator that follows no point, as the final character.
      send_char(7'd0, 1'b1);
   endtask

   task automatic test_free_flowing();
      set_separator(7'd44);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_random_streams(400);
   endtask

   task automatic test_slow_sender();
      set_separator(7'd127);
      sender_idle_pct    = 83;
      receiver_stall_pct = 0;
      run_random_streams(400);
   endtask

   task automatic test_slow_receiver();
      set_separator(CHAR_BIAS);
      sender_idle_pct    = 0;
      receiver_stall_pct = 83;
      run_random_streams(400);
   endtask

   task automatic test_both_stalling();
      set_separator(7'd0);
      sender_idle_pct    = 6;
      receiver_stall_pct = 6;
      run_random_streams(400);
   endtask

   task automatic test_random_separator();
      set_separator(CHAR_WIDTH'($urandom_range(127)));
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_random_streams(350);
   endtask

   initial begin
      clear_decoder();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_free_flowing();
      test_slow_sender();
      test_slow_receiver();
      test_both_stalling();
      test_random_separator();
      // Let every awaited word arrive, then watch a little longer for strays.
      receiver_stall_pct = 0;
      wait_for_drain();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("polyline_stream_decoder_core_tb: PASS");
      end else begin
         $display("polyline_stream_decoder_core_tb: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/psd_pkg.sv
design/psd_fifo.sv
design/psd_front.sv
design/psd_exec.sv
design/polyline_stream_decoder_core.sv
bench/polyline_stream_decoder_core_tb.sv
